[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the keypad scanner RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define KMS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked check that also holds through reset.
`define KMS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[src/kms_pkg.sv]
// ---------------------------------------------------------------------------
// kms_pkg
// Types, sizes and codes shared by the keypad matrix scanner files.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package kms_pkg;

    // matrix geometry and rollover depth
    localparam int ROWS     = 3;
    localparam int COLS     = 8;
    localparam int MAX_KEYS = 2;

    // fixed field widths
    localparam int KEY_W       = 24;
    localparam int CODE_W      = 8;
    localparam int CNT_FIELD_W = 2;
    localparam int TICK_W      = 4;
    localparam int BLINK_W     = 4;
    localparam int WARN_W      = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    // derived widths
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int COL_W = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int CNT_W = $clog2(MAX_KEYS + 1);
    localparam int IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int SH_W  = $clog2(ROWS * COLS + 1);

    // register reset values
    localparam logic [TICK_W-1:0]  SCAN_PERIOD_RST    = TICK_W'(3);
    localparam logic [BLINK_W-1:0] BLINK_SCANS_RST    = BLINK_W'(2);
    localparam logic [WARN_W-1:0]  WARNING_LENGTH_RST = WARN_W'(30);

    // item opcodes
    localparam logic OP_TICK    = 1'b0;
    localparam logic OP_WARNING = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCAN_PERIOD,
        CFG_BLINK_SCANS,
        CFG_WARNING_LENGTH
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_ROW,
        S_COMPACT,
        S_MERGE,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic row_step;
        logic compact;
        logic merge_step;
        logic commit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_hit;
        logic row_last;
        logic merge_done;
    } t_dp_sts;

    typedef struct packed {
        logic                   scanned;
        logic                   report;
        logic [CNT_FIELD_W-1:0] key_count;
        logic [CODE_W-1:0]      first_code;
        logic                   first_pressed;
        logic [CODE_W-1:0]      second_code;
        logic                   second_pressed;
        logic                   buzzer;
        logic                   led;
        logic                   warning_active;
    } t_result;

endpackage

[src/kms_if.sv]
// ---------------------------------------------------------------------------
// kms_if
// Valid/ready channels for scanner items and scanner results.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface kms_in_if;
    import kms_pkg::*;

    logic             valid;
    logic             ready;
    logic             op;
    logic [KEY_W-1:0] keys_down;
    logic             warning_on;

    modport source (output valid, output op, output keys_down, output warning_on,
                    input ready);
    modport sink   (input valid, input op, input keys_down, input warning_on,
                    output ready);
endinterface

interface kms_out_if;
    import kms_pkg::*;

    logic                   valid;
    logic                   ready;
    logic                   scanned;
    logic                   report;
    logic [CNT_FIELD_W-1:0] key_count;
    logic [CODE_W-1:0]      first_code;
    logic                   first_pressed;
    logic [CODE_W-1:0]      second_code;
    logic                   second_pressed;
    logic                   buzzer;
    logic                   led;
    logic                   warning_active;

    modport source (output valid, output scanned, output report, output key_count,
                    output first_code, output first_pressed, output second_code,
                    output second_pressed, output buzzer, output led,
                    output warning_active, input ready);
    modport sink   (input valid, input scanned, input report, input key_count,
                    input first_code, input first_pressed, input second_code,
                    input second_pressed, input buzzer, input led,
                    input warning_active, output ready);
endinterface

[src/kms_ctrl.sv]
// ---------------------------------------------------------------------------
// kms_ctrl
// Sequencer for one item: decide, row walk, list compaction, merge, commit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kms_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    input  kms_pkg::t_dp_sts  i_sts,
    output kms_pkg::t_dp_cmd  o_cmd
);
    import kms_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = i_sts.scan_hit ? S_ROW : S_FINISH;
            end
            S_ROW: begin
                o_cmd.row_step = 1'b1;
                if (i_sts.row_last) n_state = S_COMPACT;
            end
            S_COMPACT: begin
                o_cmd.compact = 1'b1;
                n_state       = S_MERGE;
            end
            S_MERGE: begin
                if (i_sts.merge_done) begin
                    n_state = S_FINISH;
                end else begin
                    o_cmd.merge_step = 1'b1;
                end
            end
            S_FINISH: begin
                // hold until the result register can take the new result
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

endmodule

[src/kms_dp.sv]
// ---------------------------------------------------------------------------
// kms_dp
// Scanner datapath: config, timers, row gather, action list, result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module kms_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [kms_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [kms_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_op,
    input  logic [kms_pkg::KEY_W-1:0]        i_keys_down,
    input  logic                             i_warning_on,
    input  kms_pkg::t_dp_cmd                 i_cmd,
    output kms_pkg::t_dp_sts                 o_sts,
    output kms_pkg::t_result                 o_result
);
    import kms_pkg::*;

    localparam logic [IDX_W-1:0] SLOT1 = IDX_W'((MAX_KEYS > 1) ? 1 : 0);

    function automatic logic [CODE_W-1:0] key_code(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
        return CODE_W'(10 * (int'(row) + 1) + int'(col) + 1);
    endfunction

    // configuration
    logic [TICK_W-1:0]  r_scan_period;
    logic [BLINK_W-1:0] r_blink_scans;
    logic [WARN_W-1:0]  r_warn_len;

    // timer and indicator state
    logic [TICK_W-1:0]  r_tick, n_tick, tick_inc;
    logic [BLINK_W-1:0] r_blink, n_blink, blink_inc;
    logic               r_led, n_led;
    logic               r_buzz, n_buzz;
    logic               r_wflag, n_wflag;
    logic [WARN_W-1:0]  r_wcount, n_wcount, wcount_inc;

    // action list
    logic [CODE_W-1:0]   r_codes [MAX_KEYS];
    logic [MAX_KEYS-1:0] r_held;
    logic [CNT_W-1:0]    r_count;

    // item and work registers
    logic             r_op;
    logic [KEY_W-1:0] r_keys;
    logic             r_warn_on;
    logic [ROW_W-1:0] r_row;
    logic [CODE_W-1:0] r_gc [MAX_KEYS];
    logic [CNT_W-1:0] r_n;
    logic [CNT_W-1:0] r_mi;
    logic             r_stop;
    logic             r_before;
    t_result          r_result, n_result;

    // gather
    logic [SH_W-1:0]   sh;
    logic [KEY_W-1:0]  keys_sh;
    logic [COLS-1:0]   row_bits;
    logic [CODE_W-1:0] n_gc [MAX_KEYS];
    logic [CNT_W-1:0]  n_gcnt;

    // compaction
    logic [CODE_W-1:0] n_cc [MAX_KEYS];
    logic [CNT_W-1:0]  n_ccount;

    // merge
    logic [CODE_W-1:0]   merge_code;
    logic [CODE_W-1:0]   n_mc [MAX_KEYS];
    logic [MAX_KEYS-1:0] n_mh;
    logic [CNT_W-1:0]    n_mcount;
    logic                n_mstop;

    logic scan_hit;
    logic pulse;

    assign tick_inc   = r_tick + TICK_W'(1);
    assign blink_inc  = r_blink + BLINK_W'(1);
    assign wcount_inc = r_wcount + WARN_W'(1);
    assign scan_hit   = (r_op == OP_TICK) && (tick_inc == r_scan_period);

    assign o_sts.scan_hit   = scan_hit;
    assign o_sts.row_last   = (r_row == ROW_W'(ROWS - 1));
    assign o_sts.merge_done = (r_mi == r_n);
    assign o_result         = r_result;

    // ---- config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_period <= SCAN_PERIOD_RST;
            r_blink_scans <= BLINK_SCANS_RST;
            r_warn_len    <= WARNING_LENGTH_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_SCAN_PERIOD:    r_scan_period <= i_cfg_data[TICK_W-1:0];
                CFG_BLINK_SCANS:    r_blink_scans <= i_cfg_data[BLINK_W-1:0];
                CFG_WARNING_LENGTH: r_warn_len    <= i_cfg_data[WARN_W-1:0];
                default: ;
            endcase
        end
    end

    // ---- one row per cycle: lowest columns, appended highest first
    assign sh       = SH_W'(int'(r_row) * COLS);
    assign keys_sh  = r_keys >> sh;
    assign row_bits = keys_sh[COLS-1:0];

    always_comb begin : gather
        int found;
        int p;
        logic [COL_W-1:0] cols [MAX_KEYS];
        found = 0;
        p     = 0;
        for (int k = 0; k < MAX_KEYS; k++) begin
            cols[k] = '0;
            n_gc[k] = r_gc[k];
        end
        for (int c = 0; c < COLS; c++) begin
            if (row_bits[c] && found < MAX_KEYS) begin
                cols[IDX_W'(found)] = COL_W'(c);
                found = found + 1;
            end
        end
        for (int k = 0; k < MAX_KEYS; k++) begin
            if (k < found) begin
                p = int'(r_n) + found - 1 - k;
                if (p < MAX_KEYS) n_gc[IDX_W'(p)] = key_code(r_row, cols[k]);
            end
        end
        if (int'(r_n) + found >= MAX_KEYS) begin
            n_gcnt = CNT_W'(MAX_KEYS);
        end else begin
            n_gcnt = CNT_W'(int'(r_n) + found);
        end
    end

    // ---- held entries move to the front, held bits cleared
    always_comb begin : compact
        int kept;
        kept = 0;
        for (int i = 0; i < MAX_KEYS; i++) n_cc[i] = r_codes[i];
        for (int i = 0; i < MAX_KEYS; i++) begin
            if (i < int'(r_count) && r_held[i]) begin
                n_cc[IDX_W'(kept)] = r_codes[i];
                kept = kept + 1;
            end
        end
        n_ccount = CNT_W'(kept);
    end

    // ---- one gathered key per cycle against the kept entries
    assign merge_code = r_gc[r_mi[IDX_W-1:0]];

    always_comb begin : merge
        logic matched;
        matched = 1'b0;
        for (int i = 0; i < MAX_KEYS; i++) n_mc[i] = r_codes[i];
        n_mh     = r_held;
        n_mcount = r_count;
        n_mstop  = r_stop;
        if (!r_stop) begin
            for (int j = 0; j < MAX_KEYS; j++) begin
                if (!matched && j < int'(r_count) && r_codes[j] == merge_code) begin
                    n_mh[j] = 1'b1;
                    matched = 1'b1;
                end
            end
            if (!matched) begin
                if (r_count < CNT_W'(MAX_KEYS)) begin
                    n_mc[r_count[IDX_W-1:0]] = merge_code;
                    n_mh[r_count[IDX_W-1:0]] = 1'b1;
                    n_mcount = r_count + CNT_W'(1);
                end else begin
                    // list full: remaining keys are ignored, even matches
                    n_mstop = 1'b1;
                end
            end
        end
    end

    // ---- item and work registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_n    <= '0;
            r_mi   <= '0;
            r_stop <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_row <= '0;
                r_n   <= '0;
            end else if (i_cmd.row_step) begin
                r_row <= r_row + ROW_W'(1);
                r_n   <= n_gcnt;
            end
            if (i_cmd.compact) begin
                r_mi   <= '0;
                r_stop <= 1'b0;
            end else if (i_cmd.merge_step) begin
                r_mi   <= r_mi + CNT_W'(1);
                r_stop <= n_mstop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_keys    <= i_keys_down;
            r_warn_on <= i_warning_on;
        end
        if (i_cmd.row_step) begin
            for (int k = 0; k < MAX_KEYS; k++) r_gc[k] <= n_gc[k];
        end
        if (i_cmd.compact) r_before <= r_held[0];
        if (i_cmd.commit) r_result <= n_result;
    end

    // ---- action list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_KEYS; k++) r_codes[k] <= '0;
            r_held  <= '0;
            r_count <= '0;
        end else if (i_cmd.compact) begin
            for (int k = 0; k < MAX_KEYS; k++) r_codes[k] <= n_cc[k];
            r_held  <= '0;
            r_count <= n_ccount;
        end else if (i_cmd.merge_step) begin
            for (int k = 0; k < MAX_KEYS; k++) r_codes[k] <= n_mc[k];
            r_held  <= n_mh;
            r_count <= n_mcount;
        end
    end

    // ---- end of item: timers, warning, buzzer, result
    assign pulse = scan_hit && (r_count != '0) && !r_before && r_held[0];

    always_comb begin
        n_tick   = r_tick;
        n_blink  = r_blink;
        n_led    = r_led;
        n_buzz   = r_buzz;
        n_wflag  = r_wflag;
        n_wcount = r_wcount;
        if (r_op == OP_WARNING) begin
            n_wflag = r_warn_on;
        end else begin
            n_tick = scan_hit ? '0 : tick_inc;
            if (scan_hit) begin
                if (blink_inc == r_blink_scans) begin
                    n_blink = '0;
                    n_led   = !r_led;
                end else begin
                    n_blink = blink_inc;
                end
            end
            if (r_wflag) begin
                if (wcount_inc >= r_warn_len) begin
                    n_wcount = '0;
                    n_wflag  = 1'b0;
                end else begin
                    n_wcount = wcount_inc;
                end
            end
            n_buzz = pulse || n_wflag;
        end
    end

    always_comb begin
        n_result                = '0;
        n_result.scanned        = scan_hit;
        n_result.report         = scan_hit && (r_count != '0);
        n_result.key_count      = CNT_FIELD_W'(r_count);
        if (r_count != '0) begin
            n_result.first_code    = r_codes[0];
            n_result.first_pressed = r_held[0];
        end
        if (MAX_KEYS > 1 && r_count > CNT_W'(1)) begin
            n_result.second_code    = r_codes[SLOT1];
            n_result.second_pressed = r_held[SLOT1];
        end
        n_result.buzzer         = n_buzz;
        n_result.led            = n_led;
        n_result.warning_active = n_wflag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_blink  <= '0;
            r_led    <= 1'b0;
            r_buzz   <= 1'b0;
            r_wflag  <= 1'b0;
            r_wcount <= '0;
        end else if (i_cmd.commit) begin
            r_tick   <= n_tick;
            r_blink  <= n_blink;
            r_led    <= n_led;
            r_buzz   <= n_buzz;
            r_wflag  <= n_wflag;
            r_wcount <= n_wcount;
        end
    end

endmodule

[src/keypad_matrix_scanner.sv]
// ---------------------------------------------------------------------------
// keypad_matrix_scanner
// Key matrix scanner with two-key rollover, LED blink and buzzer control.
// ---------------------------------------------------------------------------
// Each input transfer is either a timer tick carrying the current key-down
// mask, or a set-warning command; every one yields exactly one result
// transfer. The block works on one item at a time: a tick that does not scan
// and a set-warning item go from the decide step straight to the finish step;
// a scanning tick walks the matrix rows (one matrix row per cycle), compacts
// the action list and merges the gathered keys (one gathered key per cycle)
// through the shared datapath. A finished result sits in the output
// register, and the next item is accepted while it waits; a result is only
// held back in the last step if the previous one has still not been taken.
// Configuration writes go straight to their registers and must only be
// issued while the block is idle. No clearing pass is needed after reset.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module keypad_matrix_scanner (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [kms_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [kms_pkg::CFG_DATA_W-1:0] i_cfg_data,
    kms_in_if.sink                         i_item,
    kms_out_if.source                      o_result
);
    import kms_pkg::*;

    t_dp_cmd w_cmd;     // controller -> datapath strobes
    t_dp_sts w_sts;     // datapath -> controller flags
    t_result w_result;  // registered result payload
    logic    w_out_valid;
    logic    w_in_ready;

    // sequencer: owns the input ready and the result valid flag
    kms_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_item.valid),
        .o_in_ready  (w_in_ready),
        .i_out_ready (o_result.ready),
        .o_out_valid (w_out_valid),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // datapath: config, timers, action list and result register
    kms_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_op         (i_item.op),
        .i_keys_down  (i_item.keys_down),
        .i_warning_on (i_item.warning_on),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_result     (w_result)
    );

    assign i_item.ready            = w_in_ready;
    assign o_result.valid          = w_out_valid;
    assign o_result.scanned        = w_result.scanned;
    assign o_result.report         = w_result.report;
    assign o_result.key_count      = w_result.key_count;
    assign o_result.first_code     = w_result.first_code;
    assign o_result.first_pressed  = w_result.first_pressed;
    assign o_result.second_code    = w_result.second_code;
    assign o_result.second_pressed = w_result.second_pressed;
    assign o_result.buzzer         = w_result.buzzer;
    assign o_result.led            = w_result.led;
    assign o_result.warning_active = w_result.warning_active;

    // ---- checks
    // a commit always presents a result on the next cycle
    `KMS_ASSERT(a_commit_shows, i_clk, i_rst_n, w_cmd.commit |=> o_result.valid, "commit lost")
    // one item in flight: ready drops right after an accept
    `KMS_ASSERT(a_one_item, i_clk, i_rst_n, (i_item.valid && i_item.ready) |=> !i_item.ready, "second item accepted")
    // a held slot 0 implies a non-empty list
    `KMS_ASSERT(a_held_count, i_clk, i_rst_n, (o_result.valid && o_result.first_pressed) |-> (o_result.key_count != '0), "held key in empty list")
    // list never reports more entries than slots
    `KMS_ASSERT_ALWAYS(a_count_max, i_clk, o_result.valid |-> (o_result.key_count <= CNT_FIELD_W'(MAX_KEYS)), "list count too large")

endmodule
